/* hdl/qtg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_pkg
// Shared types, constants and the micro-program of the quintic trajectory
// generator: operation codes, operand selects and the step table.
// ----------------------------------------------------------------------------
package qtg_pkg;

    localparam int QTG_MAX_SAMPLES = 64;
    // dividend width of the shared divider: a 64-bit magnitude scaled by 2^16
    localparam int QTG_DIV_W       = 80;
    localparam int QTG_DEN_W       = 31;
    localparam int QTG_PC_W        = 7;
    // first step of the per-sample part of the program
    localparam logic [QTG_PC_W-1:0] QTG_LOOP_PC = 7'd34;

    localparam logic signed [63:0] QTG_POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] QTG_NEG_MAX = 64'sh8000_0000_0000_0001;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIVQ,
        OP_DIVN,
        OP_DIVS,
        OP_EMIT
    } qtg_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_32,
        SH_33
    } qtg_shift_t;

    typedef enum logic [4:0] {
        R_X0, R_V0, R_A0, R_XF, R_VF, R_AF,
        R_T, R_TT, R_H,
        R_W1, R_W2, R_W3, R_W4,
        R_D3, R_D4, R_D5,
        R_P, R_DV, R_DA, R_TMP, R_S
    } qtg_reg_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TIME  = 2'd1,
        ST_TRUNCATED = 2'd2
    } qtg_status_t;

    typedef struct packed {
        qtg_op_t           op;
        qtg_reg_t          dst;
        qtg_reg_t          src_a;
        qtg_reg_t          src_b;
        logic              use_imm;
        logic signed [5:0] imm;
        qtg_shift_t        shift;
    } qtg_uop_t;

    typedef struct packed {
        logic       start;
        qtg_shift_t shift;
    } qtg_mul_req_t;

    // saturating add / subtract, limits +-(2^63-1)
    function automatic logic signed [63:0] qtg_sadd(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input logic               sub);
        logic signed [64:0] s;
        s = sub ? ($signed({a[63], a}) - $signed({b[63], b}))
                : ($signed({a[63], a}) + $signed({b[63], b}));
        if (s > $signed({1'b0, QTG_POS_MAX})) begin
            return QTG_POS_MAX;
        end else if (s < $signed({1'b1, QTG_NEG_MAX})) begin
            return QTG_NEG_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [31:0] qtg_sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic qtg_uop_t u_mul(input qtg_reg_t d, input qtg_reg_t a,
                                       input qtg_reg_t b, input qtg_shift_t sh);
        return '{op: OP_MUL, dst: d, src_a: a, src_b: b, use_imm: 1'b0,
                 imm: 6'sd0, shift: sh};
    endfunction

    function automatic qtg_uop_t u_mli(input qtg_reg_t d, input qtg_reg_t a,
                                       input logic signed [5:0] c);
        return '{op: OP_MUL, dst: d, src_a: a, src_b: R_X0, use_imm: 1'b1,
                 imm: c, shift: SH_0};
    endfunction

    function automatic qtg_uop_t u_alu(input qtg_op_t o, input qtg_reg_t d,
                                       input qtg_reg_t a, input qtg_reg_t b);
        return '{op: o, dst: d, src_a: a, src_b: b, use_imm: 1'b0,
                 imm: 6'sd0, shift: SH_0};
    endfunction

    // step table: coefficient solve, then one pass per sample
    function automatic qtg_uop_t qtg_uop(input logic [QTG_PC_W-1:0] pc);
        qtg_uop_t u;
        case (pc)
            // scaled boundary terms
            7'd0:  u = u_mul(R_TT, R_T, R_T, SH_0);
            7'd1:  u = u_alu(OP_SUB, R_H, R_XF, R_X0);
            7'd2:  u = u_mul(R_W1, R_V0, R_T, SH_16);
            7'd3:  u = u_mul(R_W2, R_VF, R_T, SH_16);
            7'd4:  u = u_mul(R_W3, R_A0, R_TT, SH_33);
            7'd5:  u = u_mul(R_W4, R_AF, R_TT, SH_33);
            // cubic coefficient
            7'd6:  u = u_mli(R_D3, R_H, 6'sd10);
            7'd7:  u = u_mli(R_TMP, R_W1, -6'sd6);
            7'd8:  u = u_alu(OP_ADD, R_D3, R_D3, R_TMP);
            7'd9:  u = u_mli(R_TMP, R_W2, -6'sd4);
            7'd10: u = u_alu(OP_ADD, R_D3, R_D3, R_TMP);
            7'd11: u = u_mli(R_TMP, R_W3, -6'sd3);
            7'd12: u = u_alu(OP_ADD, R_D3, R_D3, R_TMP);
            7'd13: u = u_mli(R_TMP, R_W4, 6'sd1);
            7'd14: u = u_alu(OP_ADD, R_D3, R_D3, R_TMP);
            // quartic coefficient
            7'd15: u = u_mli(R_D4, R_H, -6'sd15);
            7'd16: u = u_mli(R_TMP, R_W1, 6'sd8);
            7'd17: u = u_alu(OP_ADD, R_D4, R_D4, R_TMP);
            7'd18: u = u_mli(R_TMP, R_W2, 6'sd7);
            7'd19: u = u_alu(OP_ADD, R_D4, R_D4, R_TMP);
            7'd20: u = u_mli(R_TMP, R_W3, 6'sd3);
            7'd21: u = u_alu(OP_ADD, R_D4, R_D4, R_TMP);
            7'd22: u = u_mli(R_TMP, R_W4, -6'sd2);
            7'd23: u = u_alu(OP_ADD, R_D4, R_D4, R_TMP);
            // quintic coefficient
            7'd24: u = u_mli(R_D5, R_H, 6'sd6);
            7'd25: u = u_mli(R_TMP, R_W1, -6'sd3);
            7'd26: u = u_alu(OP_ADD, R_D5, R_D5, R_TMP);
            7'd27: u = u_mli(R_TMP, R_W2, -6'sd3);
            7'd28: u = u_alu(OP_ADD, R_D5, R_D5, R_TMP);
            7'd29: u = u_mli(R_TMP, R_W3, -6'sd1);
            7'd30: u = u_alu(OP_ADD, R_D5, R_D5, R_TMP);
            7'd31: u = u_mli(R_TMP, R_W4, 6'sd1);
            7'd32: u = u_alu(OP_ADD, R_D5, R_D5, R_TMP);
            // sample count
            7'd33: u = u_alu(OP_DIVN, R_S, R_T, R_T);
            // normalized time of this sample
            7'd34: u = u_alu(OP_DIVS, R_S, R_T, R_T);
            // position
            7'd35: u = u_mul(R_P, R_D5, R_S, SH_32);
            7'd36: u = u_alu(OP_ADD, R_P, R_P, R_D4);
            7'd37: u = u_mul(R_P, R_P, R_S, SH_32);
            7'd38: u = u_alu(OP_ADD, R_P, R_P, R_D3);
            7'd39: u = u_mul(R_P, R_P, R_S, SH_32);
            7'd40: u = u_alu(OP_ADD, R_P, R_P, R_W3);
            7'd41: u = u_mul(R_P, R_P, R_S, SH_32);
            7'd42: u = u_alu(OP_ADD, R_P, R_P, R_W1);
            7'd43: u = u_mul(R_P, R_P, R_S, SH_32);
            7'd44: u = u_alu(OP_ADD, R_P, R_P, R_X0);
            // first derivative
            7'd45: u = u_mli(R_DV, R_D5, 6'sd5);
            7'd46: u = u_mul(R_DV, R_DV, R_S, SH_32);
            7'd47: u = u_mli(R_TMP, R_D4, 6'sd4);
            7'd48: u = u_alu(OP_ADD, R_DV, R_DV, R_TMP);
            7'd49: u = u_mul(R_DV, R_DV, R_S, SH_32);
            7'd50: u = u_mli(R_TMP, R_D3, 6'sd3);
            7'd51: u = u_alu(OP_ADD, R_DV, R_DV, R_TMP);
            7'd52: u = u_mul(R_DV, R_DV, R_S, SH_32);
            7'd53: u = u_mli(R_TMP, R_W3, 6'sd2);
            7'd54: u = u_alu(OP_ADD, R_DV, R_DV, R_TMP);
            7'd55: u = u_mul(R_DV, R_DV, R_S, SH_32);
            7'd56: u = u_mli(R_TMP, R_W1, 6'sd1);
            7'd57: u = u_alu(OP_ADD, R_DV, R_DV, R_TMP);
            // second derivative
            7'd58: u = u_mli(R_DA, R_D5, 6'sd20);
            7'd59: u = u_mul(R_DA, R_DA, R_S, SH_32);
            7'd60: u = u_mli(R_TMP, R_D4, 6'sd12);
            7'd61: u = u_alu(OP_ADD, R_DA, R_DA, R_TMP);
            7'd62: u = u_mul(R_DA, R_DA, R_S, SH_32);
            7'd63: u = u_mli(R_TMP, R_D3, 6'sd6);
            7'd64: u = u_alu(OP_ADD, R_DA, R_DA, R_TMP);
            7'd65: u = u_mul(R_DA, R_DA, R_S, SH_32);
            7'd66: u = u_mli(R_TMP, R_W3, 6'sd2);
            7'd67: u = u_alu(OP_ADD, R_DA, R_DA, R_TMP);
            // back to time units
            7'd68: u = u_alu(OP_DIVQ, R_DV, R_DV, R_DV);
            7'd69: u = u_alu(OP_DIVQ, R_DA, R_DA, R_DA);
            7'd70: u = u_alu(OP_DIVQ, R_DA, R_DA, R_DA);
            default: u = u_alu(OP_EMIT, R_TMP, R_TMP, R_TMP);
        endcase
        return u;
    endfunction

endpackage

/* hdl/quintic_trajectory_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_trajectory_generator
// Fits a quintic to start/end position, velocity and acceleration and emits
// sampled time, position, velocity and acceleration words.
// ----------------------------------------------------------------------------
//  channel  dir  fields (low bit first)
//  s_       in   x0, v0, a0, xf, vf, af (32 each), t0, tf, ts (31 each)
//  m_       out  tdata: time, position, velocity, accel; tuser: status; tlast
//
//  A request runs the coefficient solve and then one pass per sample, paced
//  by the 80-step bit-serial divider (four runs per sample) and the
//  four-pass 32x32 multiplier (21 runs per sample). Invalid timing gives one
//  status word right away. A stalled m_tready holds the sequencer at the next
//  word; s_tready is high only between requests. Synchronous active-low
//  reset; no clearing pass.
// ----------------------------------------------------------------------------
module quintic_trajectory_generator #(
    parameter int MAX_SAMPLES = qtg_pkg::QTG_MAX_SAMPLES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_position, start_velocity, start_accel, end_position, end_velocity,
    // end_accel, start_time, end_time, sample_period, zero fill
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_time, position, velocity, acceleration, zero fill
    output logic [127:0] m_tdata,
    // status
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    import qtg_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int TAU_W = QTG_DEN_W + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_MWAIT, S_DWAIT, S_EMIT, S_BAD
    } state_t;

    state_t              state_reg;
    logic [QTG_PC_W-1:0] pc_reg;
    logic [CNT_W-1:0]    idx_reg, num_reg;
    logic [1:0]          status_reg;
    logic [TAU_W-1:0]    tau_reg;

    logic signed [31:0]  x0_reg, v0_reg, a0_reg, xf_reg, vf_reg, af_reg;
    logic [30:0]         t0_reg, ts_reg, t_reg;
    logic signed [63:0]  tt_reg, h_reg, w1_reg, w2_reg, w3_reg, w4_reg;
    logic signed [63:0]  d3_reg, d4_reg, d5_reg, p_reg, dv_reg, da_reg;
    logic signed [63:0]  tmp_reg, s_reg;

    logic                m_tvalid_reg, m_tlast_reg;
    logic [127:0]        m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    qtg_uop_t            uop;
    logic signed [63:0]  op_a, op_b;
    logic [63:0]         mag_a;
    qtg_mul_req_t        mul_req;
    logic                mul_done, div_start, div_done;
    logic signed [63:0]  mul_res;
    logic [QTG_DIV_W-1:0] div_num, div_quot;
    logic [QTG_DEN_W-1:0] div_den;
    logic                wb_en;
    logic signed [63:0]  wb_val, divq_res;
    logic [62:0]         divq_mag;
    logic                out_free, out_load, accept, last_word;
    logic [TAU_W-1:0]    time_sum;
    logic [30:0]         in_t0, in_tf, in_ts;

    function automatic logic signed [63:0] rd(input qtg_reg_t r);
        case (r)
            R_X0:    return 64'(x0_reg);
            R_V0:    return 64'(v0_reg);
            R_A0:    return 64'(a0_reg);
            R_XF:    return 64'(xf_reg);
            R_VF:    return 64'(vf_reg);
            R_AF:    return 64'(af_reg);
            R_T:     return $signed({33'd0, t_reg});
            R_TT:    return tt_reg;
            R_H:     return h_reg;
            R_W1:    return w1_reg;
            R_W2:    return w2_reg;
            R_W3:    return w3_reg;
            R_W4:    return w4_reg;
            R_D3:    return d3_reg;
            R_D4:    return d4_reg;
            R_D5:    return d5_reg;
            R_P:     return p_reg;
            R_DV:    return dv_reg;
            R_DA:    return da_reg;
            R_TMP:   return tmp_reg;
            R_S:     return s_reg;
            default: return 64'sd0;
        endcase
    endfunction

    assign in_t0    = s_tdata[222:192];
    assign in_tf    = s_tdata[253:223];
    assign in_ts    = s_tdata[284:254];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = ((state_reg == S_EMIT) || (state_reg == S_BAD)) && out_free;

    // operand selection from the current step
    always_comb begin
        uop   = qtg_uop(pc_reg);
        op_a  = rd(uop.src_a);
        op_b  = uop.use_imm ? 64'(uop.imm) : rd(uop.src_b);
        mag_a = op_a[63] ? (~op_a + 64'd1) : op_a;
    end

    // shared unit launches
    always_comb begin
        mul_req.start = (state_reg == S_ISSUE) && (uop.op == OP_MUL);
        mul_req.shift = uop.shift;
        div_start     = (state_reg == S_ISSUE) &&
                        ((uop.op == OP_DIVQ) || (uop.op == OP_DIVN) || (uop.op == OP_DIVS));
        case (uop.op)
            OP_DIVN: begin
                div_num = QTG_DIV_W'(t_reg);
                div_den = ts_reg;
            end
            OP_DIVS: begin
                div_num = QTG_DIV_W'({tau_reg, 32'd0});
                div_den = t_reg;
            end
            default: begin
                div_num = {mag_a, 16'd0};
                div_den = t_reg;
            end
        endcase
    end

    qtg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    qtg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // result write-back
    always_comb begin
        divq_mag = (|div_quot[QTG_DIV_W-1:63]) ? {63{1'b1}} : div_quot[62:0];
        divq_res = op_a[63] ? -$signed({1'b0, divq_mag}) : $signed({1'b0, divq_mag});
        wb_en    = 1'b0;
        wb_val   = mul_res;
        case (state_reg)
            S_ISSUE: begin
                if ((uop.op == OP_ADD) || (uop.op == OP_SUB)) begin
                    wb_en  = 1'b1;
                    wb_val = qtg_sadd(op_a, op_b, uop.op == OP_SUB);
                end
            end
            S_MWAIT: begin
                wb_en = mul_done;
            end
            S_DWAIT: begin
                if (uop.op == OP_DIVQ) begin
                    wb_en  = div_done;
                    wb_val = divq_res;
                end else if (uop.op == OP_DIVS) begin
                    wb_en  = div_done;
                    wb_val = div_quot[63:0];
                end
            end
            default: wb_en = 1'b0;
        endcase
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            x0_reg <= s_tdata[31:0];
            v0_reg <= s_tdata[63:32];
            a0_reg <= s_tdata[95:64];
            xf_reg <= s_tdata[127:96];
            vf_reg <= s_tdata[159:128];
            af_reg <= s_tdata[191:160];
            t0_reg <= in_t0;
            ts_reg <= in_ts;
            t_reg  <= in_tf - in_t0;
        end
        if (wb_en) begin
            case (uop.dst)
                R_TT:    tt_reg  <= wb_val;
                R_H:     h_reg   <= wb_val;
                R_W1:    w1_reg  <= wb_val;
                R_W2:    w2_reg  <= wb_val;
                R_W3:    w3_reg  <= wb_val;
                R_W4:    w4_reg  <= wb_val;
                R_D3:    d3_reg  <= wb_val;
                R_D4:    d4_reg  <= wb_val;
                R_D5:    d5_reg  <= wb_val;
                R_P:     p_reg   <= wb_val;
                R_DV:    dv_reg  <= wb_val;
                R_DA:    da_reg  <= wb_val;
                R_TMP:   tmp_reg <= wb_val;
                R_S:     s_reg   <= wb_val;
                default: tmp_reg <= tmp_reg;
            endcase
        end
    end

    assign time_sum  = TAU_W'(t0_reg) + tau_reg;
    assign last_word = (idx_reg + CNT_W'(1)) == num_reg;

    // sequencer and output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        pc_reg  <= '0;
                        idx_reg <= '0;
                        tau_reg <= '0;
                        if ((in_tf <= in_t0) || (in_ts == 31'd0)) begin
                            state_reg <= S_BAD;
                        end else begin
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    case (uop.op)
                        OP_MUL:  state_reg <= S_MWAIT;
                        OP_DIVQ, OP_DIVN, OP_DIVS: state_reg <= S_DWAIT;
                        OP_EMIT: state_reg <= S_EMIT;
                        default: pc_reg <= pc_reg + QTG_PC_W'(1);
                    endcase
                end
                S_MWAIT: begin
                    if (mul_done) begin
                        pc_reg    <= pc_reg + QTG_PC_W'(1);
                        state_reg <= S_ISSUE;
                    end
                end
                S_DWAIT: begin
                    if (div_done) begin
                        if (uop.op == OP_DIVN) begin
                            if (div_quot >= QTG_DIV_W'(MAX_SAMPLES)) begin
                                num_reg    <= CNT_W'(MAX_SAMPLES);
                                status_reg <= ST_TRUNCATED;
                            end else begin
                                num_reg    <= div_quot[CNT_W-1:0] + CNT_W'(1);
                                status_reg <= ST_OK;
                            end
                        end
                        pc_reg    <= pc_reg + QTG_PC_W'(1);
                        state_reg <= S_ISSUE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, qtg_sat32(da_reg), qtg_sat32(dv_reg),
                                         qtg_sat32(p_reg), time_sum[30:0]};
                        m_tuser_reg  <= status_reg;
                        m_tlast_reg  <= last_word;
                        if (last_word) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + CNT_W'(1);
                            tau_reg   <= tau_reg + TAU_W'(ts_reg);
                            pc_reg    <= QTG_LOOP_PC;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_BAD: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= '0;
                        m_tuser_reg  <= ST_BAD_TIME;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* hdl/qtg_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_mul
// Shared signed 64x64 multiplier with truncating right shift and saturation.
// Four 32x32 partial products accumulated in turn, then a final step that truncates and saturates.
// ----------------------------------------------------------------------------
module qtg_mul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  qtg_pkg::qtg_mul_req_t req,
    input  logic signed [63:0]   op_a,
    input  logic signed [63:0]   op_b,
    output logic                 done,
    output logic signed [63:0]   result
);
    import qtg_pkg::*;

    logic               busy_reg, fin_reg, done_reg;
    logic [1:0]         step_reg;
    logic [63:0]        ua_reg, ub_reg;
    logic               neg_reg;
    qtg_shift_t         sh_reg;
    logic [127:0]       acc_reg;
    logic signed [63:0] result_reg;

    logic [31:0]  a_part, b_part;
    logic [63:0]  prod;
    logic [1:0]   place;
    logic [127:0] addend;
    logic [127:0] shifted;
    logic         ovf;
    logic [62:0]  mag;

    // partial product of the current step
    always_comb begin
        a_part  = step_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        b_part  = step_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        prod    = a_part * b_part;
        place   = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
        addend  = {64'd0, prod} << {place, 5'd0};
    end

    // truncate and saturate the full product
    always_comb begin
        case (sh_reg)
            SH_0:    shifted = acc_reg;
            SH_16:   shifted = acc_reg >> 16;
            SH_32:   shifted = acc_reg >> 32;
            SH_33:   shifted = acc_reg >> 33;
            default: shifted = acc_reg;
        endcase
        ovf = |shifted[127:63];
        mag = ovf ? {63{1'b1}} : shifted[62:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
                acc_reg  <= 128'd0;
                ua_reg   <= op_a[63] ? (~op_a + 64'd1) : op_a;
                ub_reg   <= op_b[63] ? (~op_b + 64'd1) : op_b;
                neg_reg  <= op_a[63] ^ op_b[63];
                sh_reg   <= req.shift;
            end else if (busy_reg) begin
                acc_reg  <= acc_reg + addend;
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg    <= 1'b0;
                done_reg   <= 1'b1;
                result_reg <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hdl/qtg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qtg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [qtg_pkg::QTG_DIV_W-1:0] num,
    input  logic [qtg_pkg::QTG_DEN_W-1:0] den,
    output logic                          done,
    output logic [qtg_pkg::QTG_DIV_W-1:0] quot
);
    import qtg_pkg::*;

    localparam int CNT_W = $clog2(QTG_DIV_W);

    logic                 busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [QTG_DIV_W-1:0] nq_reg;
    logic [QTG_DEN_W-1:0] rem_reg, den_reg;

    logic [QTG_DEN_W:0]   trial;
    logic                 qbit;
    logic [QTG_DEN_W:0]   diff;

    // one trial subtraction
    always_comb begin
        trial = {rem_reg, nq_reg[QTG_DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        qbit  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                nq_reg   <= num;
                den_reg  <= den;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= qbit ? diff[QTG_DEN_W-1:0] : trial[QTG_DEN_W-1:0];
                nq_reg  <= {nq_reg[QTG_DIV_W-2:0], qbit};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QTG_DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = nq_reg;

endmodule

/* tb/sv/quintic_trajectory_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_trajectory_generator_tb
// Drives trajectory requests into the generator with bursty input and a
// stalling output side. Every sample word is checked field by field against a
// bit-accurate quintic predictor kept inside this bench.
// ----------------------------------------------------------------------------
module quintic_trajectory_generator_tb;
    import qtg_pkg::*;

    localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int T_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic signed [31:0] x0, v0, a0, xf, vf, af;
        logic [30:0]        t0, tf, ts;
    } traj_req_t;

    typedef struct {
        logic [30:0] t;
        logic [31:0] pos, vel, acc;
        qtg_status_t status;
        logic        last;
    } sample_word_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    sample_word_t sample_q[$];
    int           mismatches;
    int           burst_left;
    int           hold_cycles;
    bit           hold_req;

    quintic_trajectory_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #400ms;
        $display("quintic_trajectory_generator test failed");
        $finish;
    end

    // saturating fixed-point helpers
    function automatic longint with_sign(input logic [63:0] m, input bit neg);
        if (m > I64_MAX) begin
            m = I64_MAX;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] magnitude(input longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint sat_add(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > $signed({1'b0, I64_MAX})) begin
            return longint'(I64_MAX);
        end else if (s < -$signed({1'b0, I64_MAX})) begin
            return -longint'(I64_MAX);
        end
        return longint'(s[63:0]);
    endfunction

    // trunc(a*b / 2^k) toward zero, saturated
    function automatic longint mul_shift(input longint a, input longint b, input int k);
        logic [127:0] p;
        p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> k;
        if (p[127:64] != 0) begin
            p[63:0] = I64_MAX;
        end
        return with_sign(p[63:0], (a < 0) != (b < 0));
    endfunction

    function automatic longint mul_const(input longint a, input longint c);
        return mul_shift(a, c * 65536, 16);
    endfunction

    // trunc(x * 2^16 / den) toward zero, saturated
    function automatic longint div_time(input longint x, input logic [63:0] den);
        logic [79:0] q;
        q = {magnitude(x), 16'd0} / {16'd0, den};
        if (q[79:64] != 0) begin
            return with_sign(I64_MAX, x < 0);
        end
        return with_sign(q[63:0], x < 0);
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // expected sample words of one request
    task automatic predict_trajectory(input traj_req_t r);
        longint       term[5];
        longint       d[6];
        longint       p, dv, da, s;
        logic [63:0]  span, n, tau;
        logic [127:0] sn;
        qtg_status_t  st;
        sample_word_t w;
        int           j;
        longint       c3[5] = '{10, -6, -4, -3, 1};
        longint       c4[5] = '{-15, 8, 7, 3, -2};
        longint       c5[5] = '{6, -3, -3, -1, 1};
        if (r.tf <= r.t0 || r.ts == 0) begin
            w = '{t: '0, pos: '0, vel: '0, acc: '0, status: ST_BAD_TIME, last: 1'b1};
            sample_q = {sample_q, w};
            return;
        end
        span    = 64'(r.tf) - 64'(r.t0);
        term[0] = longint'(r.xf) - longint'(r.x0);
        term[1] = mul_shift(r.v0, span, 16);
        term[2] = mul_shift(r.vf, span, 16);
        term[3] = mul_shift(r.a0, span * span, 33);
        term[4] = mul_shift(r.af, span * span, 33);
        d[0] = r.x0;
        d[1] = term[1];
        d[2] = term[3];
        d[3] = 0;
        d[4] = 0;
        d[5] = 0;
        for (j = 0; j < 5; j++) begin
            d[3] = sat_add(d[3], mul_const(term[j], c3[j]));
            d[4] = sat_add(d[4], mul_const(term[j], c4[j]));
            d[5] = sat_add(d[5], mul_const(term[j], c5[j]));
        end
        n  = span / 64'(r.ts) + 1;
        st = ST_OK;
        if (n > QTG_MAX_SAMPLES) begin
            n  = QTG_MAX_SAMPLES;
            st = ST_TRUNCATED;
        end
        for (longint i = 0; i < n; i++) begin
            tau = 64'(i) * 64'(r.ts);
            sn  = {tau, 32'd0} / {64'd0, span};
            s   = longint'(sn[63:0]);
            p   = d[5];
            dv  = mul_const(d[5], 5);
            da  = mul_const(d[5], 20);
            for (j = 4; j >= 0; j--) begin
                p = sat_add(mul_shift(p, s, 32), d[j]);
            end
            for (j = 4; j >= 1; j--) begin
                dv = sat_add(mul_shift(dv, s, 32), mul_const(d[j], j));
            end
            da = sat_add(mul_shift(da, s, 32), mul_const(d[4], 12));
            da = sat_add(mul_shift(da, s, 32), mul_const(d[3], 6));
            da = sat_add(mul_shift(da, s, 32), mul_const(d[2], 2));
            w.t      = 31'(64'(r.t0) + tau);
            w.pos    = clip32(p);
            w.vel    = clip32(div_time(dv, span));
            w.acc    = clip32(div_time(div_time(da, span), span));
            w.status = st;
            w.last   = (i + 1 == n);
            sample_q = {sample_q, w};
        end
    endtask

    // sender: one request word, idle gaps between bursts
    task automatic send_request(input traj_req_t r);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge aclk);
            burst_left = $urandom_range(1, 6);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {3'd0, r.ts, r.tf, r.t0, r.af, r.vf, r.xf, r.a0, r.v0, r.x0};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_trajectory(r);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            default: return $signed($urandom) >>> $urandom_range(0, 24);
        endcase
    endfunction

    // well-formed request with about n_hint samples
    function automatic traj_req_t rand_request(input int n_hint);
        traj_req_t   r;
        logic [30:0] span;
        r.x0 = rand_value();
        r.v0 = rand_value();
        r.a0 = rand_value();
        r.xf = rand_value();
        r.vf = rand_value();
        r.af = rand_value();
        span = 31'($urandom_range(1, T_MAX) >> $urandom_range(0, 30));
        if (span < n_hint) begin
            span = 31'(n_hint);
        end
        r.ts = (n_hint <= 1) ? span + 31'($urandom_range(0, T_MAX - span))
                             : span / 31'(n_hint - 1);
        if (r.ts == 0) begin
            r.ts = 1;
        end
        r.t0 = 31'($urandom_range(0, T_MAX - span));
        r.tf = r.t0 + span;
        return r;
    endfunction

    // checker: compare each accepted sample word with the oldest expectation
    always @(posedge aclk) begin
        sample_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word %h user %0d last %b", m_tdata, m_tuser, m_tlast);
                end
            end else begin
                e = sample_q.pop_front();
                if (m_tdata[30:0] !== e.t || m_tdata[62:31] !== e.pos
                        || m_tdata[94:63] !== e.vel || m_tdata[126:95] !== e.acc
                        || m_tdata[127] !== 1'b0 || m_tuser !== e.status
                        || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp t=%h p=%h v=%h a=%h st=%0d l=%b",
                                 e.t, e.pos, e.vel, e.acc, e.status, e.last);
                        $display("         got t=%h p=%h v=%h a=%h st=%0d l=%b",
                                 m_tdata[30:0], m_tdata[62:31], m_tdata[94:63],
                                 m_tdata[126:95], m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    initial begin
        int mode;
        int mode_left;
        m_tready    = 1'b0;
        mode        = 0;
        mode_left   = 0;
        hold_cycles = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_cycles = 3000;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 2000);
            end
            mode_left--;
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready = 1'b0;
            end else begin
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = $urandom_range(0, 1);
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic wait_drained();
        while (sample_q.size() != 0) @(negedge aclk);
    endtask

    // extremes, every status and single-sample edges
    task automatic test_directed();
        traj_req_t r;
        r = '{x0: 32'sh7FFF_FFFF, v0: 32'sh7FFF_FFFF, a0: 32'sh7FFF_FFFF,
              xf: 32'sh8000_0000, vf: 32'sh8000_0000, af: 32'sh8000_0000,
              t0: 31'd0, tf: 31'h7FFF_FFFF, ts: 31'h0800_0000};
        send_request(r);
        r.x0 = 32'sh8000_0000; r.v0 = 32'sh8000_0000; r.a0 = 32'sh8000_0000;
        r.xf = 32'sh7FFF_FFFF; r.vf = 32'sh7FFF_FFFF; r.af = 32'sh7FFF_FFFF;
        send_request(r);
        // one sample: period longer than span
        r = '{x0: 32'sh0001_0000, v0: 0, a0: 0, xf: 32'sh000A_0000, vf: 0, af: 0,
              t0: 31'd100, tf: 31'd200, ts: 31'h7FFF_FFFF};
        send_request(r);
        // span an exact multiple of the period
        r.tf = 31'h0004_0000; r.t0 = 31'd0; r.ts = 31'h0001_0000;
        send_request(r);
        // end time equal to start time, end before start, zero period
        r.tf = r.t0;
        send_request(r);
        r.t0 = 31'h7FFF_FFFF; r.tf = 31'd0;
        send_request(r);
        r.t0 = 31'd0; r.tf = 31'h0001_0000; r.ts = 31'd0;
        send_request(r);
        // sample count at the limit: exactly 64, one over (truncated) and far more than 64
        r = rand_request(2);
        r.t0 = 31'd0; r.tf = 31'd63; r.ts = 31'd1;
        send_request(r);
        r.tf = 31'd64;
        send_request(r);
        r.tf = 31'h7FFF_FFFF;
        send_request(r);
        // smallest span
        r = rand_request(1);
        r.t0 = 31'h7FFF_FFFE; r.tf = 31'h7FFF_FFFF; r.ts = 31'd1;
        send_request(r);
        for (int i = 0; i < 8; i++) begin
            send_request(rand_request($urandom_range(1, 4)));
        end
    endtask

    // output held off long while requests keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_request(rand_request($urandom_range(1, 3)));
        end
    endtask

    // sender waits for the block to empty out
    task automatic test_drain_pause();
        s_tvalid   = 1'b0;
        burst_left = 0;
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            send_request(rand_request($urandom_range(1, 3)));
        end
    endtask

    task automatic test_random(input int count);
        traj_req_t r;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 39))
                0: r = rand_request($urandom_range(64, 200));
                1, 2: begin
                    r    = rand_request(2);
                    r.tf = 31'($urandom_range(0, r.t0));
                end
                3: begin
                    r    = rand_request(2);
                    r.ts = 31'd0;
                end
                default: r = rand_request($urandom_range(1, 4));
            endcase
            send_request(r);
        end
    endtask

    initial begin
        mismatches = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(230);
        s_tvalid = 1'b0;
        wait_drained();
        repeat (1000) @(posedge aclk);
        if (mismatches == 0 && sample_q.size() == 0) begin
            $display("quintic_trajectory_generator test passed");
        end else begin
            $display("quintic_trajectory_generator test failed");
        end
        $finish;
    end

endmodule
